// ===== sv/comb_sort_by_timestamp_core_defines.svh =====
// Assertion macros for the comb sort block's datapath module.
`ifndef COMB_SORT_BY_TIMESTAMP_CORE_DEFINES_SVH
`define COMB_SORT_BY_TIMESTAMP_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define CSBT_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("comb sort assertion failed");

// Next-cycle implication, checked outside reset.
`define CSBT_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("comb sort assertion failed");

`endif

// ===== sv/csbt_pkg.sv =====
// Types, constants, microcode table and gap shrink function of the comb sort block.
package csbt_pkg;

	localparam int MAX_RECORDS = 64;
	localparam int KEY_W       = 48;
	localparam int KEY_BITS    = 48;
	localparam int TAG_W       = 6;
	localparam int IDX_W       = $clog2(MAX_RECORDS);
	localparam int CNT_W       = IDX_W + 1;
	localparam int STEP_W      = 4;

	// Gap shrink by 1.3 is done as floor(g * 10 / 13).
	localparam int SHRINK_NUM  = 10;
	localparam int SHRINK_DEN  = 13;
	localparam int RECIP_SHIFT = 16;
	localparam int RECIP       = (2 ** RECIP_SHIFT) / SHRINK_DEN;
	localparam int PROD_W      = CNT_W + 4;
	localparam int MUL_W       = PROD_W + RECIP_SHIFT + 1;

	typedef struct packed {
		logic [KEY_W-1:0] time_key;
		logic [TAG_W-1:0] record_tag;
		logic             last_in_set;
	} rec_t;

	typedef struct packed {
		logic [KEY_W-1:0] sorted_key;
		logic [TAG_W-1:0] sorted_tag;
		logic             last_out;
		logic             overflow;
	} res_t;

	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [TAG_W-1:0] tag;
	} entry_t;

	typedef enum logic [3:0] {
		A_NONE,
		A_LOAD,
		A_GAP_INIT,
		A_PASS_INIT,
		A_READ,
		A_WR_LO,
		A_WR_HI,
		A_STEP,
		A_OCLEAR,
		A_ORD,
		A_EMIT,
		A_DONE
	} act_t;

	typedef enum logic [3:0] {
		C_NEVER,
		C_ALWAYS,
		C_NOT_CLOSE,
		C_FEW,
		C_NOT_GT,
		C_MORE_PAIRS,
		C_AGAIN,
		C_BUSY,
		C_MORE_OUT
	} cond_t;

	typedef logic [STEP_W-1:0] step_t;

	localparam step_t ST_LOAD   = step_t'(0);
	localparam step_t ST_INIT   = step_t'(1);
	localparam step_t ST_PASS   = step_t'(2);
	localparam step_t ST_READ   = step_t'(3);
	localparam step_t ST_CMP    = step_t'(4);
	localparam step_t ST_SWAP1  = step_t'(5);
	localparam step_t ST_SWAP2  = step_t'(6);
	localparam step_t ST_STEP   = step_t'(7);
	localparam step_t ST_CHK    = step_t'(8);
	localparam step_t ST_OSTART = step_t'(9);
	localparam step_t ST_ORD    = step_t'(10);
	localparam step_t ST_OPUT   = step_t'(11);
	localparam step_t ST_OLOOP  = step_t'(12);
	localparam step_t ST_DONE   = step_t'(13);

	// One control word: what the datapath does, and where to branch when cond holds.
	typedef struct packed {
		act_t  act;
		cond_t cond;
		step_t target;
	} uword_t;

	typedef struct packed {
		logic closing;
		logic few;
		logic gt;
		logic more_pairs;
		logic again;
		logic busy;
		logic more_out;
	} status_t;

	function automatic uword_t ucode(step_t s);
		uword_t w;
		w = '{act: A_NONE, cond: C_ALWAYS, target: ST_LOAD};
		case (s)
			ST_LOAD:   w = '{act: A_LOAD,      cond: C_NOT_CLOSE,  target: ST_LOAD};
			ST_INIT:   w = '{act: A_GAP_INIT,  cond: C_FEW,        target: ST_OSTART};
			ST_PASS:   w = '{act: A_PASS_INIT, cond: C_NEVER,      target: ST_LOAD};
			ST_READ:   w = '{act: A_READ,      cond: C_NEVER,      target: ST_LOAD};
			ST_CMP:    w = '{act: A_NONE,      cond: C_NOT_GT,     target: ST_STEP};
			ST_SWAP1:  w = '{act: A_WR_LO,     cond: C_NEVER,      target: ST_LOAD};
			ST_SWAP2:  w = '{act: A_WR_HI,     cond: C_NEVER,      target: ST_LOAD};
			ST_STEP:   w = '{act: A_STEP,      cond: C_MORE_PAIRS, target: ST_READ};
			ST_CHK:    w = '{act: A_NONE,      cond: C_AGAIN,      target: ST_PASS};
			ST_OSTART: w = '{act: A_OCLEAR,    cond: C_NEVER,      target: ST_LOAD};
			ST_ORD:    w = '{act: A_ORD,       cond: C_NEVER,      target: ST_LOAD};
			ST_OPUT:   w = '{act: A_EMIT,      cond: C_BUSY,       target: ST_OPUT};
			ST_OLOOP:  w = '{act: A_NONE,      cond: C_MORE_OUT,   target: ST_ORD};
			ST_DONE:   w = '{act: A_DONE,      cond: C_ALWAYS,     target: ST_LOAD};
			default:   w = '{act: A_NONE,      cond: C_ALWAYS,     target: ST_LOAD};
		endcase
		return w;
	endfunction

	// floor(g * 10 / 13) by a reciprocal multiply, which may come out one low,
	// followed by a single remainder correction.
	function automatic logic [CNT_W-1:0] shrink_gap(logic [CNT_W-1:0] g);
		logic [PROD_W-1:0] p;
		logic [MUL_W-1:0]  m;
		logic [PROD_W-1:0] q;
		logic [PROD_W-1:0] r;
		p = PROD_W'(g) * PROD_W'(SHRINK_NUM);
		m = MUL_W'(p) * MUL_W'(RECIP);
		q = m[RECIP_SHIFT +: PROD_W];
		r = p - PROD_W'(q * PROD_W'(SHRINK_DEN));
		if (r >= PROD_W'(SHRINK_DEN)) begin
			q = q + PROD_W'(1);
		end
		return q[CNT_W-1:0];
	endfunction

endpackage

// ===== sv/comb_sort_by_timestamp_core.sv =====
// Records load at one per cycle while the sequencer is in its load step. After the closing
// item the sort runs a gap setup step, then per pass a pass setup step, a read, compare and
// step per compared pair, a low and a high write per swap, and a check step. Output: a start
// step, then per record a read, an emit through the output register and a loop check, then
// a closing step; a held output register holds the sequencer until it drains. Sets are
// handled one at a time. Reset (arst_n, asynchronous, active low) clears the step counter,
// fill count, gap and flags; the store is not cleared, only the current set is read.
module comb_sort_by_timestamp_core (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            rec_valid,
	output logic            rec_stall,
	input  csbt_pkg::rec_t  rec_item,
	output logic            srt_valid,
	input  logic            srt_stall,
	output csbt_pkg::res_t  srt_item
);

	csbt_pkg::uword_t  uw;
	csbt_pkg::status_t st;

	csbt_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.st     (st),
		.uw     (uw)
	);

	csbt_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.uw        (uw),
		.st        (st),
		.rec_valid (rec_valid),
		.rec_stall (rec_stall),
		.rec_item  (rec_item),
		.srt_valid (srt_valid),
		.srt_stall (srt_stall),
		.srt_item  (srt_item)
	);

endmodule

// ===== sv/csbt_seq.sv =====
// Microcode sequencer: step counter, control word table and conditional branches.
module csbt_seq (
	input  logic               clk,
	input  logic               arst_n,
	input  csbt_pkg::status_t  st,
	output csbt_pkg::uword_t   uw
);

	csbt_pkg::step_t step_q;
	csbt_pkg::step_t step_d;
	logic            take;

	assign uw = csbt_pkg::ucode(step_q);

	always_comb begin
		case (uw.cond)
			csbt_pkg::C_NEVER:      take = 1'b0;
			csbt_pkg::C_ALWAYS:     take = 1'b1;
			csbt_pkg::C_NOT_CLOSE:  take = !st.closing;
			csbt_pkg::C_FEW:        take = st.few;
			csbt_pkg::C_NOT_GT:     take = !st.gt;
			csbt_pkg::C_MORE_PAIRS: take = st.more_pairs;
			csbt_pkg::C_AGAIN:      take = st.again;
			csbt_pkg::C_BUSY:       take = st.busy;
			csbt_pkg::C_MORE_OUT:   take = st.more_out;
			default:                take = 1'b0;
		endcase
		step_d = take ? uw.target : step_q + csbt_pkg::step_t'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= csbt_pkg::ST_LOAD;
		end else begin
			step_q <= step_d;
		end
	end

endmodule

// ===== sv/csbt_dp.sv =====
// Datapath: record store, counters, gap and swap flags, compare and output register.
`include "comb_sort_by_timestamp_core_defines.svh"

module csbt_dp (
	input  logic               clk,
	input  logic               arst_n,
	input  csbt_pkg::uword_t   uw,
	output csbt_pkg::status_t  st,
	input  logic               rec_valid,
	output logic               rec_stall,
	input  csbt_pkg::rec_t     rec_item,
	output logic               srt_valid,
	input  logic               srt_stall,
	output csbt_pkg::res_t     srt_item
);

	csbt_pkg::entry_t mem [csbt_pkg::MAX_RECORDS];

	logic [csbt_pkg::CNT_W-1:0] fill_q;
	logic [csbt_pkg::CNT_W-1:0] idx_q;
	logic [csbt_pkg::IDX_W-1:0] gap_q;
	logic                       swap_q;
	logic                       ovf_q;
	csbt_pkg::entry_t           rda_q;
	csbt_pkg::entry_t           rdb_q;
	csbt_pkg::res_t             out_q;
	logic                       out_v_q;

	logic                       rec_acc;
	logic                       full;
	logic                       slot_free;
	logic                       emit;
	logic [csbt_pkg::CNT_W-1:0] idx_inc;
	logic [csbt_pkg::IDX_W-1:0] pair_hi;
	logic [csbt_pkg::CNT_W:0]   pair_end;
	logic [csbt_pkg::CNT_W:0]   next_end;
	logic [csbt_pkg::CNT_W-1:0] shr_in;
	logic [csbt_pkg::CNT_W-1:0] shr_out;
	logic [csbt_pkg::IDX_W-1:0] pass_gap;
	logic                       wr_en;
	logic [csbt_pkg::IDX_W-1:0] wr_addr;
	csbt_pkg::entry_t           wr_data;
	logic                       rd_en;

	assign rec_stall = (uw.act != csbt_pkg::A_LOAD);
	assign rec_acc   = rec_valid && (uw.act == csbt_pkg::A_LOAD);
	assign full      = (fill_q == csbt_pkg::CNT_W'(csbt_pkg::MAX_RECORDS));
	assign slot_free = !out_v_q || !srt_stall;
	assign emit      = (uw.act == csbt_pkg::A_EMIT) && slot_free;
	assign idx_inc   = idx_q + csbt_pkg::CNT_W'(1);
	assign pair_hi   = idx_q[csbt_pkg::IDX_W-1:0] + gap_q;
	assign pair_end  = {1'b0, idx_q} + (csbt_pkg::CNT_W+1)'(gap_q);
	assign next_end  = {1'b0, idx_inc} + (csbt_pkg::CNT_W+1)'(gap_q);

	// One shrink unit serves both the initial gap and the per-pass shrink.
	assign shr_in  = (uw.act == csbt_pkg::A_GAP_INIT) ? fill_q : csbt_pkg::CNT_W'(gap_q);
	assign shr_out = csbt_pkg::shrink_gap(shr_in);

	always_comb begin
		pass_gap = (gap_q > csbt_pkg::IDX_W'(1)) ? shr_out[csbt_pkg::IDX_W-1:0] : gap_q;
		if (pass_gap == '0) begin
			pass_gap = csbt_pkg::IDX_W'(1);
		end
	end

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = idx_q[csbt_pkg::IDX_W-1:0];
		wr_data = rdb_q;
		case (uw.act)
			csbt_pkg::A_LOAD: begin
				wr_en   = rec_acc && !full;
				wr_addr = fill_q[csbt_pkg::IDX_W-1:0];
				wr_data = '{key: csbt_pkg::KEY_W'(rec_item.time_key[csbt_pkg::KEY_BITS-1:0]),
					tag: rec_item.record_tag};
			end
			csbt_pkg::A_WR_LO: begin
				wr_en = 1'b1;
			end
			csbt_pkg::A_WR_HI: begin
				wr_en   = 1'b1;
				wr_addr = pair_hi;
				wr_data = rda_q;
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	// Reads only on explicit steps, so the pair data holds through a swap.
	assign rd_en = (uw.act == csbt_pkg::A_READ) || (uw.act == csbt_pkg::A_ORD);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rda_q <= mem[idx_q[csbt_pkg::IDX_W-1:0]];
			rdb_q <= mem[pair_hi];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			idx_q  <= '0;
			gap_q  <= '0;
			swap_q <= 1'b0;
			ovf_q  <= 1'b0;
		end else begin
			case (uw.act)
				csbt_pkg::A_LOAD: begin
					if (rec_acc) begin
						if (!full) begin
							fill_q <= fill_q + csbt_pkg::CNT_W'(1);
						end else begin
							ovf_q <= 1'b1;
						end
					end
				end
				csbt_pkg::A_GAP_INIT: begin
					gap_q <= shr_out[csbt_pkg::IDX_W-1:0];
				end
				csbt_pkg::A_PASS_INIT: begin
					gap_q  <= pass_gap;
					swap_q <= 1'b0;
					idx_q  <= '0;
				end
				csbt_pkg::A_WR_LO: begin
					swap_q <= 1'b1;
				end
				csbt_pkg::A_STEP: begin
					idx_q <= idx_inc;
				end
				csbt_pkg::A_OCLEAR: begin
					idx_q <= '0;
				end
				csbt_pkg::A_EMIT: begin
					if (slot_free) begin
						idx_q <= idx_inc;
					end
				end
				csbt_pkg::A_DONE: begin
					fill_q <= '0;
					ovf_q  <= 1'b0;
					idx_q  <= '0;
				end
				default: begin
					fill_q <= fill_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (emit) begin
			out_v_q <= 1'b1;
		end else if (!srt_stall) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_q <= '{sorted_key: rda_q.key, sorted_tag: rda_q.tag,
				last_out: (idx_inc == fill_q), overflow: ovf_q};
		end
	end

	assign srt_valid = out_v_q;
	assign srt_item  = out_q;

	assign st.closing    = rec_valid && rec_item.last_in_set;
	assign st.few        = (fill_q < csbt_pkg::CNT_W'(2));
	assign st.gt         = rda_q.key[csbt_pkg::KEY_BITS-1:0] > rdb_q.key[csbt_pkg::KEY_BITS-1:0];
	assign st.more_pairs = (next_end < (csbt_pkg::CNT_W+1)'(fill_q));
	assign st.again      = (gap_q > csbt_pkg::IDX_W'(1)) || swap_q;
	assign st.busy       = !slot_free;
	assign st.more_out   = (idx_q < fill_q);

	`CSBT_ASSERT_NOW(a_ovf_only_when_full, ovf_q, full)
	`CSBT_ASSERT_NOW(a_idx_bound, 1'b1, idx_q <= fill_q)
	`CSBT_ASSERT_NOW(a_pair_in_set, uw.act == csbt_pkg::A_READ,
		(gap_q != '0) && (pair_end < (csbt_pkg::CNT_W+1)'(fill_q)))
	`CSBT_ASSERT_NEXT(a_last_ends_set, emit && (idx_inc == fill_q), idx_q == fill_q)

endmodule
